// ===== hw/rtl/sfpp_pkg.sv =====
// shared constants, result type and widths for the framed packet parser
package sfpp_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  SYNC_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [7:0]  CMD_PROGRAM = 8'h02;

    localparam int MAX_LEN_DEFAULT = 256;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    typedef logic [15:0] crc_t;
    typedef logic [7:0]  byte_t;

    typedef struct packed {
        logic        kind;
        logic        last_frame;
        logic [8:0]  frame_length;
        logic [15:0] frame_total;
        logic [15:0] frame_number;
        logic        crc_ok;
        logic [7:0]  payload_index;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

// ===== hw/rtl/sfpp_crc16_byte.sv =====
// one byte of the crc-16 modbus update, reflected form
module sfpp_crc16_byte (
    input  sfpp_pkg::crc_t  crc_in,
    input  sfpp_pkg::byte_t data_in,
    output sfpp_pkg::crc_t  crc_out
);
    import sfpp_pkg::*;

    always_comb begin
        crc_t acc;
        acc = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ CRC_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        crc_out = acc;
    end

endmodule

// ===== hw/rtl/sync_framed_packet_parser_crc16.sv =====
// framed packet parser with crc-16 modbus check, top level
//
//  channel   dir  tdata                                   tuser
//  s_        in   rx_byte[7:0]                            -
//  m_        out  payload byte/index, verdict fields      result_kind
//
// one byte per cycle while s_tready is high: each byte is parsed and its crc folded in by one layer
// of logic between the state registers and the result register
// a payload byte gives a result and the low crc byte gives the verdict, each registered into the
// result register, or into the skid while that register is stalled; other bytes give none
// a two-entry output (result register plus skid) keeps s_tready high while
// one result waits; aresetn clears the phase and both output entries
module sync_framed_packet_parser_crc16 #(
    parameter int MAX_LEN = sfpp_pkg::MAX_LEN_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfpp_pkg::IN_TDATA_W-1:0]    s_tdata,  // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [16] crc_ok, [32:17] frame_number,
    // [48:33] frame_total, [57:49] frame_length, [58] last_frame, [63:59] zero
    output logic [sfpp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tuser   // [0] result_kind
);
    import sfpp_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        PH_SYNC1, PH_SYNC2, PH_CMD, PH_LEN_H, PH_LEN_L, PH_FRM_H, PH_FRM_L,
        PH_TOT_H, PH_TOT_L, PH_DATA, PH_CRC_H, PH_CRC_L
    } phase_t;

    phase_t           phase_reg, phase_next;
    crc_t             crc_reg, crc_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [15:0]      number_reg, number_next;
    logic [15:0]      total_reg, total_next;
    logic [CNT_W-1:0] taken_reg, taken_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;

    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;
    logic    res_valid;

    logic            s_accept, m_accept;
    byte_t           rx_byte;
    crc_t            crc_upd;
    logic [15:0]     len_full;
    logic [CNT_W:0]  taken_inc;
    crc_t            crc_rx;
    logic            crc_match;

    assign rx_byte  = s_tdata[7:0];
    assign s_tready = ~skid_valid_reg;
    assign s_accept = s_tvalid & s_tready;
    assign m_accept = out_valid_reg & m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {5'b0, out_reg.last_frame, out_reg.frame_length, out_reg.frame_total,
                       out_reg.frame_number, out_reg.crc_ok, out_reg.payload_index,
                       out_reg.payload_byte};

    sfpp_crc16_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_upd)
    );

    assign len_full  = {len_hi_reg, rx_byte};
    assign taken_inc = {1'b0, taken_reg} + (CNT_W + 1)'(1);
    assign crc_rx    = {crc_hi_reg, rx_byte};
    assign crc_match = (crc_rx == crc_reg);

    always_comb begin
        phase_next  = phase_reg;
        crc_next    = crc_reg;
        len_hi_next = len_hi_reg;
        len_next    = len_reg;
        number_next = number_reg;
        total_next  = total_reg;
        taken_next  = taken_reg;
        crc_hi_next = crc_hi_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (s_accept) begin
            unique case (phase_reg)
                PH_SYNC2: begin
                    if (rx_byte == SYNC_SECOND) begin
                        crc_next   = CRC_INIT;
                        phase_next = PH_CMD;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CMD: begin
                    crc_next   = crc_upd;
                    phase_next = (rx_byte == CMD_PROGRAM) ? PH_LEN_H : PH_SYNC1;
                end
                PH_LEN_H: begin
                    crc_next    = crc_upd;
                    len_hi_next = rx_byte;
                    phase_next  = PH_LEN_L;
                end
                PH_LEN_L: begin
                    crc_next = crc_upd;
                    len_next = CNT_W'(len_full);
                    // zero or oversize length drops back to hunting for sync
                    if (len_full == 16'd0 || len_full > 16'(MAX_LEN)) begin
                        phase_next = PH_SYNC1;
                    end else begin
                        phase_next = PH_FRM_H;
                    end
                end
                PH_FRM_H: begin
                    crc_next    = crc_upd;
                    number_next = {rx_byte, 8'h00};
                    phase_next  = PH_FRM_L;
                end
                PH_FRM_L: begin
                    crc_next    = crc_upd;
                    number_next = {number_reg[15:8], rx_byte};
                    phase_next  = PH_TOT_H;
                end
                PH_TOT_H: begin
                    crc_next   = crc_upd;
                    total_next = {rx_byte, 8'h00};
                    phase_next = PH_TOT_L;
                end
                PH_TOT_L: begin
                    crc_next   = crc_upd;
                    total_next = {total_reg[15:8], rx_byte};
                    taken_next = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    crc_next          = crc_upd;
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = rx_byte;
                    res.payload_index = 8'(taken_reg);
                    taken_next        = CNT_W'(taken_inc);
                    if (taken_inc >= {1'b0, len_reg}) begin
                        phase_next = PH_CRC_H;
                    end
                end
                PH_CRC_H: begin
                    crc_hi_next = rx_byte;
                    phase_next  = PH_CRC_L;
                end
                PH_CRC_L: begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_VERDICT;
                    res.crc_ok       = crc_match;
                    res.frame_number = number_reg;
                    res.frame_total  = total_reg;
                    res.frame_length = 9'(len_reg);
                    res.last_frame   = crc_match & (number_reg == total_reg);
                    phase_next       = PH_SYNC1;
                end
                default: begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SYNC1;
            crc_reg        <= CRC_INIT;
            len_hi_reg     <= '0;
            len_reg        <= '0;
            number_reg     <= '0;
            total_reg      <= '0;
            taken_reg      <= '0;
            crc_hi_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            crc_reg    <= crc_next;
            len_hi_reg <= len_hi_next;
            len_reg    <= len_next;
            number_reg <= number_next;
            total_reg  <= total_next;
            taken_reg  <= taken_next;
            crc_hi_reg <= crc_hi_next;

            // skid holds a result only while the output register is stalled
            if (skid_valid_reg) begin
                if (m_accept) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (res_valid) begin
                if (!out_valid_reg || m_accept) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_accept) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
// testbench for the framed packet parser: random and directed byte streams against a model
`timescale 1ns / 100ps

module testbench;
    import sfpp_pkg::*;

    localparam int FRAME_MAX    = MAX_LEN_DEFAULT;
    localparam int RANDOM_BYTES = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int FORCED_HOLD  = 400;
    localparam int HOLD_AT_BYTE = 300;

    typedef enum logic [3:0] {
        PH_HUNT, PH_SYNC2, PH_CMD, PH_LEN_HI, PH_LEN_LO, PH_NUM_HI, PH_NUM_LO,
        PH_TOT_HI, PH_TOT_LO, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO
    } parse_phase_e;

    typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_style_e;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;

    // bytes still to be sent and results the parser owes
    byte_t   tx_bytes[$];
    result_t results_due[$];

    // parser model state
    parse_phase_e ph       = PH_HUNT;
    crc_t         crc_acc  = CRC_INIT;
    logic [15:0]  len_hdr  = '0;
    logic [15:0]  num_hdr  = '0;
    logic [15:0]  tot_hdr  = '0;
    logic [15:0]  taken    = '0;
    byte_t        crc_hi   = '0;

    int bytes_in     = 0;
    int mismatches   = 0;
    int payload_seen = 0;
    int verdicts     = 0;
    int good_crc     = 0;
    int last_seen    = 0;
    int frames_sent  = 0;
    int cycle_count  = 0;

    int burst_left = 0;
    int gap_left   = 0;

    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           mode_left = 0;
    int           sparse_cnt = 0;
    ready_style_e ready_style = READY_ALWAYS;

    sync_framed_packet_parser_crc16 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic crc_t crc_fold(crc_t c, byte_t b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // advance the parser model by one byte, queue the result it gives if any
    function automatic void parse_byte(byte_t b);
        result_t r;
        r = '0;
        case (ph)
            PH_HUNT: ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            PH_SYNC2: begin
                if (b == SYNC_SECOND) begin
                    crc_acc = CRC_INIT;
                    ph = PH_CMD;
                end else begin
                    ph = PH_HUNT;
                end
            end
            PH_CMD: begin
                crc_acc = crc_fold(crc_acc, b);
                ph = (b == CMD_PROGRAM) ? PH_LEN_HI : PH_HUNT;
            end
            PH_LEN_HI: begin
                crc_acc = crc_fold(crc_acc, b);
                len_hdr = {b, 8'h00};
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                crc_acc = crc_fold(crc_acc, b);
                len_hdr[7:0] = b;
                ph = (len_hdr == 0 || len_hdr > FRAME_MAX) ? PH_HUNT : PH_NUM_HI;
            end
            PH_NUM_HI: begin
                crc_acc = crc_fold(crc_acc, b);
                num_hdr = {b, 8'h00};
                ph = PH_NUM_LO;
            end
            PH_NUM_LO: begin
                crc_acc = crc_fold(crc_acc, b);
                num_hdr[7:0] = b;
                ph = PH_TOT_HI;
            end
            PH_TOT_HI: begin
                crc_acc = crc_fold(crc_acc, b);
                tot_hdr = {b, 8'h00};
                ph = PH_TOT_LO;
            end
            PH_TOT_LO: begin
                crc_acc = crc_fold(crc_acc, b);
                tot_hdr[7:0] = b;
                taken = '0;
                ph = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc = crc_fold(crc_acc, b);
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = taken[7:0];
                taken = taken + 16'd1;
                if (taken >= len_hdr)
                    ph = PH_CRC_HI;
                results_due.push_back(r);
            end
            PH_CRC_HI: begin
                crc_hi = b;
                ph = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                r.kind = KIND_VERDICT;
                r.crc_ok = ({crc_hi, b} == crc_acc);
                r.frame_number = num_hdr;
                r.frame_total = tot_hdr;
                r.frame_length = len_hdr[8:0];
                r.last_frame = r.crc_ok && (num_hdr == tot_hdr);
                ph = PH_HUNT;
                results_due.push_back(r);
            end
            default: ph = PH_HUNT;
        endcase
    endfunction

    // header stops after the command or the length when those are rejected
    task automatic queue_frame(input byte_t cmd, input logic [15:0] len,
                               input logic [15:0] num, input logic [15:0] tot,
                               input crc_t crc_flip, input bit all_ones);
        byte_t fr[$];
        crc_t  c;
        fr.push_back(SYNC_FIRST);
        fr.push_back(SYNC_SECOND);
        fr.push_back(cmd);
        if (cmd == CMD_PROGRAM) begin
            fr.push_back(len[15:8]);
            fr.push_back(len[7:0]);
            if (len != 0 && len <= FRAME_MAX) begin
                fr.push_back(num[15:8]);
                fr.push_back(num[7:0]);
                fr.push_back(tot[15:8]);
                fr.push_back(tot[7:0]);
                for (int i = 0; i < len; i++)
                    fr.push_back(all_ones ? 8'hFF : byte_t'($urandom));
                c = CRC_INIT;
                for (int i = 2; i < fr.size(); i++)
                    c = crc_fold(c, fr[i]);
                c = c ^ crc_flip;
                fr.push_back(c[15:8]);
                fr.push_back(c[7:0]);
                frames_sent++;
            end
        end
        foreach (fr[i])
            tx_bytes.push_back(fr[i]);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (tx_bytes.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= tx_bytes.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: one long forced hold, rare random holds, otherwise changing stall styles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
            hold_done = 1'b1;
            hold_left = FORCED_HOLD;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 999) == 0) begin
            hold_left = $urandom_range(100, 300);
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_style = ready_style_e'($urandom_range(0, 2));
                mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            sparse_cnt++;
            case (ready_style)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                default:      m_tready <= (sparse_cnt % 4 == 0);
            endcase
        end
    end

    // monitor: model every accepted byte, check every accepted result
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
                bytes_in <= bytes_in + 1;
            end
            if (m_tvalid && m_tready) begin
                // tdata bits 58:0 line up with the packed result below the kind bit
                got = {m_tuser, m_tdata[58:0]};
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d tdata %h", m_tuser, m_tdata);
                end else begin
                    want = results_due.pop_front();
                    if (want.kind == KIND_VERDICT) begin
                        verdicts++;
                        if (want.crc_ok) good_crc++;
                        if (want.last_frame) last_seen++;
                    end else begin
                        payload_seen++;
                    end
                    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                        got.payload_index !== want.payload_index ||
                        got.crc_ok !== want.crc_ok || got.frame_number !== want.frame_number ||
                        got.frame_total !== want.frame_total ||
                        got.frame_length !== want.frame_length ||
                        got.last_frame !== want.last_frame || m_tdata[63:59] !== 5'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: kind/byte/idx/ok/num/tot/len/last ",
                                      "want %0d %h %0d %0d %h %h %0d %0d got %0d %h %0d %0d ",
                                      "%h %h %0d %0d pad %h"},
                                     want.kind, want.payload_byte, want.payload_index,
                                     want.crc_ok, want.frame_number, want.frame_total,
                                     want.frame_length, want.last_frame,
                                     got.kind, got.payload_byte, got.payload_index,
                                     got.crc_ok, got.frame_number, got.frame_total,
                                     got.frame_length, got.last_frame, m_tdata[63:59]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout: %0d bytes unsent, %0d results outstanding",
                     tx_bytes.size(), results_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int          frame_bytes;
        int          mark;
        int          pick;
        int          len;
        logic [15:0] num;
        logic [15:0] tot;
        byte_t       b;
        crc_t        flip;
        bit          max_done;

        frame_bytes = 0;
        max_done = 1'b0;

        // good last frame with all-ones frame number, frame total and payload
        queue_frame(CMD_PROGRAM, 16'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1);
        // a second sync byte of 0x55 must not restart the hunt, so the rest is ignored
        tx_bytes.push_back(SYNC_FIRST);
        tx_bytes.push_back(SYNC_FIRST);
        tx_bytes.push_back(SYNC_SECOND);
        tx_bytes.push_back(CMD_PROGRAM);
        queue_frame(8'h03, 16'd1, 16'h0, 16'h0, 16'h0, 1'b0);
        queue_frame(CMD_PROGRAM, 16'd0, 16'h0, 16'h0, 16'h0, 1'b0);
        queue_frame(CMD_PROGRAM, 16'(FRAME_MAX + 1), 16'h0, 16'h0, 16'h0, 1'b0);

        while (frame_bytes < RANDOM_BYTES) begin
            mark = tx_bytes.size();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                // line noise, mostly ignored by the hunt
                repeat ($urandom_range(1, 6))
                    tx_bytes.push_back(byte_t'($urandom));
                mark = tx_bytes.size();
            end else if (pick < 22) begin
                case ($urandom_range(0, 2))
                    0: begin
                        tx_bytes.push_back(SYNC_FIRST);
                        do b = byte_t'($urandom); while (b == SYNC_SECOND);
                        tx_bytes.push_back(b);
                    end
                    1: begin
                        do b = byte_t'($urandom); while (b == CMD_PROGRAM);
                        queue_frame(b, 16'd0, 16'h0, 16'h0, 16'h0, 1'b0);
                    end
                    default: queue_frame(CMD_PROGRAM,
                                         ($urandom_range(0, 3) == 0) ? 16'd0 :
                                         16'($urandom_range(FRAME_MAX + 1, 65535)),
                                         16'h0, 16'h0, 16'h0, 1'b0);
                endcase
            end else begin
                if (!max_done && frame_bytes >= 250) begin
                    len = FRAME_MAX;
                    max_done = 1'b1;
                end else if ($urandom_range(0, 9) < 7) begin
                    len = $urandom_range(1, 8);
                end else begin
                    len = $urandom_range(9, 48);
                end
                case ($urandom_range(0, 3))
                    0:       num = 16'h0000;
                    1:       num = 16'hFFFF;
                    default: num = 16'($urandom);
                endcase
                tot = ($urandom_range(0, 1) == 0) ? num : 16'($urandom);
                flip = ($urandom_range(0, 5) == 0) ? crc_t'($urandom_range(1, 16'hFFFF)) : '0;
                queue_frame(CMD_PROGRAM, 16'(len), num, tot, flip, 1'b0);
            end
            frame_bytes += tx_bytes.size() - mark;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (tx_bytes.size() != 0 || s_tvalid);
        while (results_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("sent %0d bytes carrying %0d complete frames plus noise and rejected headers",
                 bytes_in, frames_sent);
        $display("checked %0d payload items and %0d verdicts (%0d crc good, %0d last frame)",
                 payload_seen, verdicts, good_crc, last_seen);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
